// ===== rtl/core/seven_segment_display_controller_assert.svh =====
`ifndef SEVEN_SEGMENT_DISPLAY_CONTROLLER_ASSERT_SVH
`define SEVEN_SEGMENT_DISPLAY_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssd_pkg.sv =====
package ssd_pkg;

  typedef enum logic [2:0] {
    OP_WRITE_CHAR = 3'd0,
    OP_CURSOR_ABS = 3'd1,
    OP_CURSOR_REL = 3'd2,
    OP_CURSOR_DIR = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_TICK       = 3'd5,
    OP_ON         = 3'd6,
    OP_OFF        = 3'd7
  } req_op_e;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_REFRESH = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         char_code;
    logic               end_of_string;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [2:0] cursor_col;
    logic [2:0] cursor_row;
    logic [7:0] segment_lines;
    logic [7:0] digit_lines;
  } rsp_t;

  typedef struct packed {
    logic    exec;
    req_op_e op;
  } cmd_t;

  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharFirst = 8'h20;
  localparam logic [7:0] CharLast  = 8'h7E;

  localparam logic [7:0] Font [95] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h67, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h00,
    8'h00, 8'h77, 8'h7F, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h0E, 8'h00, 8'h38, 8'h00, 8'h37, 8'h3F,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
    8'h00, 8'h6E, 8'h00, 8'h39, 8'h64, 8'h0F, 8'h00, 8'h08,
    8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h04, 8'h0E, 8'h00, 8'h18, 8'h00, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h22
  };

  function automatic logic [7:0] font_lookup(logic [7:0] ch);
    logic [7:0] offs;
    offs = ch - CharFirst;
    if (ch >= CharFirst && ch <= CharLast) begin
      return Font[offs[6:0]];
    end
    return 8'h00;
  endfunction

  // layout dimension clamped to 1..8
  function automatic logic [3:0] eff_dim(logic [3:0] v);
    if (v == 4'd0) begin
      return 4'd1;
    end
    if (v > 4'd8) begin
      return 4'd8;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/seven_segment_display_controller.sv =====
// result beat is valid in the cycle after the request beat is accepted
// throughput: one request per cycle while out_ready_i is high, set by the request datapath
// and the one-entry result register, which is refilled in the cycle it drains
// reset: asynchronous active low; cells blank, cursor and scan at zero,
// scanning on, next tick steps the scan, layout 8x1, refresh period 1
module seven_segment_display_controller #(
  parameter int unsigned DIGITS   = 8,
  parameter int unsigned SEGMENTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssd_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssd_pkg::rsp_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);

  ssd_pkg::cmd_t cmd;

  ssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ssd_datapath #(
    .DIGITS   (DIGITS),
    .SEGMENTS (SEGMENTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (out_data_o)
  );

endmodule

// ===== rtl/core/ssd_ctrl.sv =====
module ssd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        req_type_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output ssd_pkg::cmd_t     cmd_o
);

  ssd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ssd_pkg::ST_EMPTY: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ssd_pkg::ST_FULL;
        end
      end
      ssd_pkg::ST_FULL: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i && !in_valid_i) begin
          state_d = ssd_pkg::ST_EMPTY;
        end
      end
      default: begin
        state_d = ssd_pkg::ST_EMPTY;
      end
    endcase
    cmd_o.exec = in_valid_i && in_ready_o;
    cmd_o.op   = ssd_pkg::req_op_e'(req_type_i);
  end

endmodule

// ===== rtl/core/ssd_datapath.sv =====
module ssd_datapath #(
  parameter int unsigned DIGITS   = 8,
  parameter int unsigned SEGMENTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssd_pkg::cmd_t  cmd_i,
  input  ssd_pkg::req_t  req_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  output ssd_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [7:0] SegMask = 8'((16'd1 << SEGMENTS) - 16'd1);
  localparam logic [IdxW-1:0] LastPos = IdxW'(DIGITS - 1);
  localparam logic [6:0] DigitsW = 7'(DIGITS);

  logic [3:0]  columns_q, rows_q;
  logic [15:0] period_q;

  logic [6:0]        cell_q [DIGITS];
  logic [6:0]        cell_d [DIGITS];
  logic [DIGITS-1:0] dot_q, dot_d;
  logic [2:0]        col_q, col_d, row_q, row_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              scan_en_q, scan_en_d;
  logic [15:0]       count_q, count_d;
  logic              drop_q, drop_d;
  logic [7:0]        seg_q, seg_d, dig_q, dig_d;
  logic              status_q, status_d;

  logic [3:0]      cols, rws;
  logic [6:0]      idx, idx_m1;
  logic [7:0]      glyph;
  logic [17:0]     x_sum, y_sum;
  logic            rel;
  logic [IdxW-1:0] scan_nxt, wr_addr, dot_addr;

  assign cols     = ssd_pkg::eff_dim(columns_q);
  assign rws      = ssd_pkg::eff_dim(rows_q);
  assign idx      = ({4'b0, row_q} * {3'b0, cols}) + {4'b0, col_q};
  assign idx_m1   = idx - 7'd1;
  assign wr_addr  = idx[IdxW-1:0];
  assign dot_addr = idx_m1[IdxW-1:0];
  assign glyph    = ssd_pkg::font_lookup(req_i.char_code);
  assign rel      = (cmd_i.op == ssd_pkg::OP_CURSOR_REL);
  assign x_sum    = 18'(req_i.pos_x) + (rel ? {15'b0, col_q} : 18'd0);
  assign y_sum    = 18'(req_i.pos_y) + (rel ? {15'b0, row_q} : 18'd0);
  assign scan_nxt = (scan_q == LastPos) ? '0 : scan_q + 1'b1;

  always_comb begin
    cell_d    = cell_q;
    dot_d     = dot_q;
    col_d     = col_q;
    row_d     = row_q;
    scan_d    = scan_q;
    scan_en_d = scan_en_q;
    count_d   = count_q;
    drop_d    = drop_q;
    seg_d     = seg_q;
    dig_d     = dig_q;
    status_d  = 1'b0;
    case (cmd_i.op)
      ssd_pkg::OP_WRITE_CHAR: begin
        if (drop_q) begin
          if (req_i.end_of_string) begin
            drop_d = 1'b0;
          end
        end else if (req_i.char_code == ssd_pkg::CharDot && idx != 7'd0) begin
          if (idx_m1 < DigitsW) begin
            dot_d[dot_addr] = 1'b1;
          end
        end else if (idx >= DigitsW) begin
          if (!req_i.end_of_string) begin
            drop_d = 1'b1;
          end
        end else begin
          cell_d[wr_addr] = glyph[6:0];
          dot_d[wr_addr]  = glyph[7];
          if ({1'b0, col_q} < cols - 4'd1) begin
            col_d = col_q + 3'd1;
          end else if ({1'b0, row_q} < rws - 4'd1) begin
            col_d = 3'd0;
            row_d = row_q + 3'd1;
          end
        end
      end
      ssd_pkg::OP_CURSOR_ABS, ssd_pkg::OP_CURSOR_REL: begin
        if (x_sum[17] || y_sum[17] || x_sum >= {14'b0, cols} || y_sum >= {14'b0, rws}) begin
          status_d = 1'b1;
        end else begin
          col_d = x_sum[2:0];
          row_d = y_sum[2:0];
        end
      end
      ssd_pkg::OP_CURSOR_DIR: begin
        status_d = 1'b1;
      end
      ssd_pkg::OP_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) begin
          cell_d[i] = '0;
        end
        dot_d  = '0;
        col_d  = 3'd0;
        row_d  = 3'd0;
        drop_d = 1'b0;
      end
      ssd_pkg::OP_TICK: begin
        if (scan_en_q) begin
          if (count_q != 16'd0) begin
            count_d = count_q - 16'd1;
          end else begin
            scan_d  = scan_nxt;
            seg_d   = {dot_q[scan_nxt], cell_q[scan_nxt]} & SegMask;
            dig_d   = 8'd1 << scan_nxt;
            count_d = (period_q == 16'd0) ? 16'd0 : period_q - 16'd1;
          end
        end
      end
      ssd_pkg::OP_ON: begin
        scan_d    = '0;
        count_d   = 16'd0;
        dig_d     = 8'd0;
        scan_en_d = 1'b1;
      end
      ssd_pkg::OP_OFF: begin
        scan_d    = '0;
        dig_d     = 8'd0;
        scan_en_d = 1'b0;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGITS; i++) begin
        cell_q[i] <= '0;
      end
      dot_q     <= '0;
      col_q     <= 3'd0;
      row_q     <= 3'd0;
      scan_q    <= '0;
      scan_en_q <= 1'b1;
      count_q   <= 16'd0;
      drop_q    <= 1'b0;
      seg_q     <= 8'd0;
      dig_q     <= 8'd0;
      status_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      cell_q    <= cell_d;
      dot_q     <= dot_d;
      col_q     <= col_d;
      row_q     <= row_d;
      scan_q    <= scan_d;
      scan_en_q <= scan_en_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      seg_q     <= seg_d;
      dig_q     <= dig_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 4'd8;
      rows_q    <= 4'd1;
      period_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (ssd_pkg::cfg_reg_e'(cfg_idx_i))
        ssd_pkg::CFG_COLUMNS: columns_q <= cfg_data_i[3:0];
        ssd_pkg::CFG_ROWS:    rows_q    <= cfg_data_i[3:0];
        ssd_pkg::CFG_REFRESH: period_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign rsp_o.status        = status_q;
  assign rsp_o.cursor_col    = col_q;
  assign rsp_o.cursor_row    = row_q;
  assign rsp_o.segment_lines = seg_q;
  assign rsp_o.digit_lines   = dig_q;

endmodule

// ===== rtl/core/ssd_checker.sv =====
`include "seven_segment_display_controller_assert.svh"

module ssd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ssd_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ssd_pkg::rsp_t out_data_o
);

  logic in_beat;
  logic clear_beat;
  logic off_beat;
  logic at_home;
  logic dig_onehot;
  logic digits_dark;

  assign in_beat     = in_valid_i && in_ready_o;
  assign clear_beat  = in_beat && (in_data_i.req_type == ssd_pkg::OP_CLEAR);
  assign off_beat    = in_beat && (in_data_i.req_type == ssd_pkg::OP_OFF);
  assign at_home     = (out_data_o.cursor_col == 3'd0) && (out_data_o.cursor_row == 3'd0);
  assign dig_onehot  = $onehot0(out_data_o.digit_lines);
  assign digits_dark = (out_data_o.digit_lines == 8'd0);

  `SSD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped")
  `SSD_ASSERT_NOW(a_dig_onehot, out_valid_o, dig_onehot, "digit lines not one-hot")
  `SSD_ASSERT_NEXT(a_clear_home, clear_beat, out_valid_o && at_home, "clear left cursor off home")
  `SSD_ASSERT_NEXT(a_off_dark, off_beat, out_valid_o && digits_dark, "off left a digit lit")

endmodule

bind seven_segment_display_controller ssd_checker u_ssd_checker (.*);
